// ----- sv/assert_macros.svh -----
// Assertion macros shared by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold on every clock edge outside reset.
`define GSVC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("controller assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define GSVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("controller assertion failed");
`else
`define GSVC_ASSERT(label, clk, rst_n, prop)
`define GSVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/gsvc_pkg.sv -----
// Shared constants for the goal-seeking velocity controller.
package gsvc_pkg;

  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned VEL_W      = 24;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GOAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CTRL = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_RUNNING = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_LANDING = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_H = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_V = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VLIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

  localparam logic [GAIN_W-1:0]  GAIN_H_RESET = 18'd52429;
  localparam logic [GAIN_W-1:0]  GAIN_V_RESET = 18'd32768;
  localparam logic [LIMIT_W-1:0] VLIMIT_RESET = 23'd131072;
  localparam logic [LIMIT_W-1:0] RADIUS_RESET = 23'd32768;

endpackage

// ----- sv/goal_seeking_velocity_controller.sv -----
// Goal-seeking velocity controller: proportional position control with clamping.
// Each request passes through the input register and then the output register.
// Throughput: one request per cycle unless the output stalls; the flight state and
// goal are updated as a request leaves the input register, so the next request sees them at once.
// Reset: asynchronous and active low; phase idle, no goal, registers at defaults.
`include "assert_macros.svh"

module goal_seeking_velocity_controller import gsvc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic        [MODE_W-1:0]      mode_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic                          enable_i,
  // Results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          cmd_valid_o,
  output logic signed [VEL_W-1:0]       vel_forward_o,
  output logic signed [VEL_W-1:0]       vel_lateral_o,
  output logic signed [VEL_W-1:0]       vel_vertical_o,
  output logic                          land_pulse_o,
  output logic                          arrived_o,
  output logic                          accepted_o,
  output logic        [PHASE_W-1:0]     flight_state_o,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned MAG_W = COORD_WIDTH + 1;
  localparam int unsigned CMP_W = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;
  localparam int unsigned SQ_W  = 2 * LIMIT_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  // Everything one result carries, held together in the output register.
  typedef struct packed {
    logic                      cmd_valid;
    logic signed [VEL_W-1:0]   vel_forward;
    logic signed [VEL_W-1:0]   vel_lateral;
    logic signed [VEL_W-1:0]   vel_vertical;
    logic                      land_pulse;
    logic                      arrived;
    logic                      accepted;
    logic [PHASE_W-1:0]        flight_state;
  } res_t;

  // Configuration registers
  logic [GAIN_W-1:0]  gain_h_q, gain_v_q;
  logic [LIMIT_W-1:0] vlimit_q, radius_q;

  // Input register
  logic                          s1_valid_q;
  logic [MODE_W-1:0]             s1_mode_q;
  logic signed [COORD_WIDTH-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                          s1_enable_q;

  // Controller state
  logic [PHASE_W-1:0]            phase_q, phase_d;
  logic                          goal_valid_q, goal_valid_d;
  logic signed [COORD_WIDTH-1:0] goal_x_q, goal_y_q, goal_z_q;
  logic signed [COORD_WIDTH-1:0] goal_x_d, goal_y_d, goal_z_d;

  // Output register
  logic out_valid_q;
  res_t res_q, res_d;

  // Handshake
  logic s2_ready, fire, in_take;

  // Per-axis datapath
  logic [MAG_W-1:0]        mag_x, mag_y, mag_z;
  logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
  logic [CMP_W-1:0]        ax_ext, ay_ext, az_ext, rad_ext;
  logic [SQ_W-1:0]         sq_x, sq_y, sq_z, rad_sq;
  logic [SUM_W-1:0]        sq_sum;
  logic                    near, arrive;

  // Conditions watched by the assertions
  logic arrive_fire, at_rest, out_accepted, out_moving;

  // The output register frees up when it is empty or being taken, so a new request
  // can enter while a finished result still waits downstream.
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  gsvc_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .goal_i (goal_x_q), .pos_i (s1_x_q), .gain_i (gain_h_q), .limit_i (vlimit_q),
    .mag_o  (mag_x),    .vel_o (vel_x)
  );
  gsvc_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .goal_i (goal_y_q), .pos_i (s1_y_q), .gain_i (gain_h_q), .limit_i (vlimit_q),
    .mag_o  (mag_y),    .vel_o (vel_y)
  );
  gsvc_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
    .goal_i (goal_z_q), .pos_i (s1_z_q), .gain_i (gain_v_q), .limit_i (vlimit_q),
    .mag_o  (mag_z),    .vel_o (vel_z)
  );

  // Arrival test: every axis error must lie below the radius, which also keeps each
  // error within the width of the radius, and then the squared distance must lie
  // strictly below the squared radius.
  assign ax_ext  = CMP_W'(mag_x);
  assign ay_ext  = CMP_W'(mag_y);
  assign az_ext  = CMP_W'(mag_z);
  assign rad_ext = CMP_W'(radius_q);
  assign near    = (ax_ext < rad_ext) && (ay_ext < rad_ext) && (az_ext < rad_ext);
  assign sq_x    = SQ_W'(ax_ext[LIMIT_W-1:0]) * SQ_W'(ax_ext[LIMIT_W-1:0]);
  assign sq_y    = SQ_W'(ay_ext[LIMIT_W-1:0]) * SQ_W'(ay_ext[LIMIT_W-1:0]);
  assign sq_z    = SQ_W'(az_ext[LIMIT_W-1:0]) * SQ_W'(az_ext[LIMIT_W-1:0]);
  assign rad_sq  = SQ_W'(radius_q) * SQ_W'(radius_q);
  assign sq_sum  = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign arrive  = near && (sq_sum < SUM_W'(rad_sq));

  // Result and next state for the request in the input register.
  always_comb begin
    res_d        = '0;
    phase_d      = phase_q;
    goal_valid_d = goal_valid_q;
    goal_x_d     = goal_x_q;
    goal_y_d     = goal_y_q;
    goal_z_d     = goal_z_q;
    unique case (s1_mode_q)
      MODE_TICK: begin
        res_d.cmd_valid = 1'b1;
        if (phase_q == PHASE_LANDING) begin
          // The landing command goes out once, then the controller rests.
          res_d.land_pulse = 1'b1;
          phase_d          = PHASE_IDLE;
        end else if (phase_q == PHASE_RUNNING && goal_valid_q) begin
          if (arrive) begin
            res_d.arrived = 1'b1;
            goal_valid_d  = 1'b0;
            phase_d       = PHASE_IDLE;
          end else begin
            res_d.vel_forward  = vel_x;
            res_d.vel_lateral  = vel_y;
            res_d.vel_vertical = vel_z;
          end
        end
      end
      MODE_GOAL: begin
        goal_x_d     = s1_x_q;
        goal_y_d     = s1_y_q;
        goal_z_d     = s1_z_q;
        goal_valid_d = 1'b1;
      end
      MODE_CTRL: begin
        if (s1_enable_q) begin
          // Flight starts only towards a known goal.
          if (goal_valid_q) begin
            phase_d        = PHASE_RUNNING;
            res_d.accepted = 1'b1;
          end
        end else begin
          phase_d        = PHASE_LANDING;
          res_d.accepted = 1'b1;
        end
      end
      default: begin
        // The spare mode code changes nothing and reports the phase.
      end
    endcase
    res_d.flight_state = phase_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_h_q <= GAIN_H_RESET;
      gain_v_q <= GAIN_V_RESET;
      vlimit_q <= VLIMIT_RESET;
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GAIN_H: gain_h_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_V: gain_v_q <= cfg_data_i[GAIN_W-1:0];
        CFG_VLIMIT: vlimit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[LIMIT_W-1:0];
      endcase
    end
  end

  // Handshake and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PHASE_IDLE;
      goal_valid_q <= 1'b0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      goal_z_q     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q  <= 1'b1;
        phase_q      <= phase_d;
        goal_valid_q <= goal_valid_d;
        goal_x_q     <= goal_x_d;
        goal_y_q     <= goal_y_d;
        goal_z_q     <= goal_z_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q   <= mode_i;
      s1_x_q      <= pos_x_i;
      s1_y_q      <= pos_y_i;
      s1_z_q      <= pos_z_i;
      s1_enable_q <= enable_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_valid_o    = res_q.cmd_valid;
  assign vel_forward_o  = res_q.vel_forward;
  assign vel_lateral_o  = res_q.vel_lateral;
  assign vel_vertical_o = res_q.vel_vertical;
  assign land_pulse_o   = res_q.land_pulse;
  assign arrived_o      = res_q.arrived;
  assign accepted_o     = res_q.accepted;
  assign flight_state_o = res_q.flight_state;

  assign arrive_fire  = fire && res_d.arrived;
  assign at_rest      = !goal_valid_q && (phase_q == PHASE_IDLE);
  assign out_accepted = out_valid_o && accepted_o;
  assign out_moving   = out_valid_o && ((vel_forward_o != '0) || (vel_lateral_o != '0) ||
                                        (vel_vertical_o != '0));

  // Running always has a goal to head for.
  `GSVC_ASSERT(a_running_has_goal, clk_i, rst_ni, (phase_q != PHASE_RUNNING) || goal_valid_q)
  // Arrival clears the goal and brings the controller to rest.
  `GSVC_ASSERT_NEXT(a_arrival_clears, clk_i, rst_ni, arrive_fire, at_rest)
  // An accepted control request always leaves the controller out of idle.
  `GSVC_ASSERT(a_accept_not_idle, clk_i, rst_ni, !out_accepted || (flight_state_o != PHASE_IDLE))
  // A non-zero velocity is only ever commanded while running.
  `GSVC_ASSERT(a_vel_when_running, clk_i, rst_ni, !out_moving || (flight_state_o == PHASE_RUNNING))

endmodule

// ----- sv/gsvc_axis.sv -----
// One axis: position error, its magnitude and the clamped proportional velocity.
module gsvc_axis import gsvc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic signed [COORD_WIDTH-1:0] goal_i,
  input  logic signed [COORD_WIDTH-1:0] pos_i,
  input  logic        [GAIN_W-1:0]      gain_i,
  input  logic        [LIMIT_W-1:0]     limit_i,
  output logic        [COORD_WIDTH:0]   mag_o,
  output logic signed [VEL_W-1:0]       vel_o
);

  localparam int unsigned MAG_W  = COORD_WIDTH + 1;
  localparam int unsigned PROD_W = MAG_W + GAIN_W + 1;
  localparam int unsigned SHR_W  = PROD_W - GAIN_FRAC;
  localparam int unsigned CLP_W  = (SHR_W > LIMIT_W) ? SHR_W : LIMIT_W;
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (GAIN_FRAC - 1);

  logic [MAG_W-1:0]  diff;
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SHR_W-1:0]  shr;
  logic [CLP_W-1:0]  shr_ext;
  logic [CLP_W-1:0]  lim_ext;
  logic [LIMIT_W-1:0] sat;
  logic [VEL_W-1:0]  vel_mag;

  // The error needs one extra bit so that it never wraps.
  assign diff = {goal_i[COORD_WIDTH-1], goal_i} - {pos_i[COORD_WIDTH-1], pos_i};
  assign neg  = diff[MAG_W-1];
  assign mag  = neg ? (~diff + {{(MAG_W-1){1'b0}}, 1'b1}) : diff;

  // Rounding to nearest on the magnitude gives ties away from zero.
  assign prod    = (PROD_W'(mag) * PROD_W'(gain_i)) + RND;
  assign shr     = prod[PROD_W-1:GAIN_FRAC];
  assign shr_ext = CLP_W'(shr);
  assign lim_ext = CLP_W'(limit_i);
  assign sat     = (shr_ext > lim_ext) ? limit_i : shr_ext[LIMIT_W-1:0];
  assign vel_mag = {1'b0, sat};

  assign mag_o = mag;
  assign vel_o = neg ? (~vel_mag + {{(VEL_W-1){1'b0}}, 1'b1}) : vel_mag;

endmodule
